/* hdl/gzdf_pkg.sv */
package gzdf_pkg;

  localparam int unsigned TrailerDepth = 8;
  localparam int unsigned ZlibTrailerDepth = 4;
  localparam int unsigned DelayIdxW = $clog2(TrailerDepth);
  localparam int unsigned FillW = $clog2(TrailerDepth + 1);

  localparam logic [4:0] ByteCountMax = 5'd18;
  localparam logic [4:0] ZlibMinBytes = 5'd6;
  localparam logic [4:0] GzipMinBytes = 5'd18;

  localparam logic [7:0] GzipMagic0 = 8'h1F;
  localparam logic [7:0] GzipMagic1 = 8'h8B;
  localparam logic [7:0] FlagFextra = 8'h04;
  localparam logic [7:0] FlagFname = 8'h08;
  localparam logic [7:0] FlagFcomment = 8'h10;
  localparam logic [7:0] FlagFhcrc = 8'h02;
  localparam logic [3:0] ZlibCmDeflate = 4'h8;
  localparam logic [3:0] ZlibCinfoMax = 4'd7;

  typedef enum logic [1:0] {
    FMT_RAW  = 2'd0,
    FMT_ZLIB = 2'd1,
    FMT_GZIP = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_e;

  typedef enum logic [2:0] {
    PH_FIXED    = 3'd0,
    PH_XLEN_LO  = 3'd1,
    PH_XLEN_HI  = 3'd2,
    PH_EXTRA    = 3'd3,
    PH_FNAME    = 3'd4,
    PH_FCOMMENT = 3'd5,
    PH_HCRC     = 3'd6,
    PH_DATA     = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_BAD_ZLIB_HDR = 4'd2,
    ST_BAD_MAGIC    = 4'd3,
    ST_TRUNC_XLEN   = 4'd4,
    ST_TRUNC_EXTRA  = 4'd5,
    ST_TRUNC_NAME   = 4'd6,
    ST_TRUNC_CMNT   = 4'd7,
    ST_TRUNC_HCRC   = 4'd8,
    ST_TRUNC_DATA   = 4'd9
  } status_e;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [3:0]  status_code;
    logic [31:0] expected_check;
    logic [31:0] trailer_isize;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // first enabled optional gzip field at or after phase p
  function automatic phase_e next_field(phase_e p, logic [7:0] flags);
    phase_e r;
    r = PH_DATA;
    if (p <= PH_XLEN_LO && (flags & FlagFextra) != 8'd0) begin
      r = PH_XLEN_LO;
    end else if (p <= PH_FNAME && (flags & FlagFname) != 8'd0) begin
      r = PH_FNAME;
    end else if (p <= PH_FCOMMENT && (flags & FlagFcomment) != 8'd0) begin
      r = PH_FCOMMENT;
    end else if (p <= PH_HCRC && (flags & FlagFhcrc) != 8'd0) begin
      r = PH_HCRC;
    end
    return r;
  endfunction

  // x mod 31 == 0, folding 5-bit digits since 32 = 1 mod 31
  function automatic logic mod31_zero(logic [15:0] x);
    logic [6:0] s1;
    logic [5:0] s2;
    s1 = 7'(x[4:0]) + 7'(x[9:5]) + 7'(x[14:10]) + 7'(x[15]);
    s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
    return (s2 == 6'd0) || (s2 == 6'd31);
  endfunction

endpackage

/* hdl/gzip_zlib_container_deframer_unit.sv */
// Channel  Dir  Handshake                    Contents
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: container byte, tlast: final byte
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: payload, status, check, size
//                                            tuser: is_status, tlast: last of run
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_data_i: container format
//
// One byte accepted per cycle; the parser updates its state in the accept cycle
// and pushes zero, one or two results into a 4-entry output queue, drained one per
// cycle while m_axis_tready is high; a result waits behind those queued before it.
// Input is taken while at most two results wait, so with a stalled output
// s_axis_tready drops once three or more are queued. Asynchronous active-low reset
// returns to raw format and the start of a container; a format write also restarts.
module gzip_zlib_container_deframer_unit
  import gzdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,     // container_format

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] status_code,
                                      // [43:12] expected_check, [75:44] trailer_isize
  output logic [0:0]  m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  result_pair_t res;
  logic         in_acc, cfg_we, pop;
  result_t      q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  result_t      head;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = cnt_q <= QCntW'(QDepth - 2);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  gzdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_fmt_i   (cfg_data_i),
    .in_accept_i (in_acc),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .res_o       (res)
  );

  assign head          = q_mem[rd_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {4'd0, head.trailer_isize, head.expected_check,
                          head.status_code, head.payload_byte};
  assign m_axis_tuser  = head.is_status;
  assign m_axis_tlast  = head.last_of_run;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      wr_d  = wr_q + QPtrW'(res.count);
      cnt_d = cnt_q + QCntW'(res.count);
    end
    if (pop) begin
      rd_d  = rd_q + QPtrW'(1);
      cnt_d = cnt_d - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (res.count != 2'd0) q_mem[wr_q] <= res.first;
      if (res.count == 2'd2) q_mem[wr_q + QPtrW'(1)] <= res.second;
    end
  end

endmodule

/* hdl/gzdf_parser.sv */
module gzdf_parser
  import gzdf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_fmt_i,
  input  logic         in_accept_i,
  input  logic [7:0]   in_byte_i,
  input  logic         in_last_i,
  output result_pair_t res_o
);

  fmt_e        fmt_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] skip_q, skip_d;
  logic [4:0]  bcnt_q, bcnt_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [3:0]  err_q, err_d;
  logic [7:0]  delay_q [TrailerDepth];
  logic [7:0]  delay_d [TrailerDepth];

  logic             is_zlib, is_gzip, wrapped;
  logic [FillW-1:0] tdepth;
  logic [DelayIdxW-1:0] tail_idx;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [3:0]       code;
  logic [31:0]      chk, sz;
  logic [4:0]       need;
  result_t          pay_r, st_r;

  always_comb begin
    is_zlib  = (fmt_q == FMT_ZLIB);
    is_gzip  = (fmt_q == FMT_GZIP);
    wrapped  = is_zlib || is_gzip;
    tdepth   = is_zlib ? FillW'(ZlibTrailerDepth) : FillW'(TrailerDepth);
    tail_idx = DelayIdxW'(tdepth - FillW'(1));

    phase_d = phase_q;
    flags_d = flags_q;
    first_d = first_q;
    skip_d  = skip_q;
    fill_d  = fill_q;
    err_d   = err_q;
    for (int i = 0; i < TrailerDepth; i++) begin
      delay_d[i] = delay_q[i];
    end
    bcnt_d    = (bcnt_q < ByteCountMax) ? bcnt_q + 5'd1 : bcnt_q;
    emit      = 1'b0;
    emit_byte = in_byte_i;

    if (!wrapped) begin
      emit = 1'b1;
    end else if (phase_q == PH_DATA) begin
      if (fill_q < tdepth) begin
        delay_d[DelayIdxW'(fill_q)] = in_byte_i;
        fill_d = fill_q + FillW'(1);
      end else begin
        emit      = 1'b1;
        emit_byte = delay_q[0];
        for (int i = 0; i < TrailerDepth - 1; i++) begin
          if (i < int'(tdepth) - 1) delay_d[i] = delay_q[i+1];
        end
        delay_d[tail_idx] = in_byte_i;
      end
    end else if (is_zlib) begin
      if (bcnt_q == 5'd0) begin
        first_d = in_byte_i;
      end else begin
        if ((first_q[3:0] != ZlibCmDeflate || first_q[7:4] > ZlibCinfoMax ||
             !mod31_zero({first_q, in_byte_i})) && err_q == ST_OK) begin
          err_d = ST_BAD_ZLIB_HDR;
        end
        phase_d = PH_DATA;
      end
    end else begin
      unique case (phase_q)
        PH_FIXED: begin
          if (bcnt_q == 5'd0) begin
            first_d = in_byte_i;
          end else if (bcnt_q == 5'd1 &&
                       (first_q != GzipMagic0 || in_byte_i != GzipMagic1)) begin
            if (err_q == ST_OK) err_d = ST_BAD_MAGIC;
          end else if (bcnt_q == 5'd3) begin
            flags_d = in_byte_i;
          end
          if (bcnt_q >= 5'd9) phase_d = next_field(PH_XLEN_LO, flags_q);
        end
        PH_XLEN_LO: begin
          skip_d  = {8'd0, in_byte_i};
          phase_d = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_d  = {in_byte_i, skip_q[7:0]};
          phase_d = (skip_d == 16'd0) ? next_field(PH_FNAME, flags_q) : PH_EXTRA;
        end
        PH_EXTRA: begin
          skip_d = skip_q - 16'd1;
          if (skip_d == 16'd0) phase_d = next_field(PH_FNAME, flags_q);
        end
        PH_FNAME: begin
          if (in_byte_i == 8'd0) phase_d = next_field(PH_FCOMMENT, flags_q);
        end
        PH_FCOMMENT: begin
          if (in_byte_i == 8'd0) phase_d = next_field(PH_HCRC, flags_q);
        end
        PH_HCRC: begin
          skip_d = skip_q - 16'd1;
          if (skip_d == 16'd0) phase_d = PH_DATA;
        end
        PH_DATA: begin
          phase_d = PH_DATA;
        end
      endcase
      if (phase_q != PH_HCRC && phase_d == PH_HCRC) skip_d = 16'd2;
    end

    // end-of-container status, from the updated state
    need = is_zlib ? ZlibMinBytes : GzipMinBytes;
    code = ST_OK;
    chk  = 32'd0;
    sz   = 32'd0;
    if (wrapped) begin
      priority if (bcnt_d < need) begin
        code = ST_SHORT;
      end else if (err_d != ST_OK) begin
        code = err_d;
      end else if (phase_d == PH_XLEN_LO || phase_d == PH_XLEN_HI) begin
        code = ST_TRUNC_XLEN;
      end else if (phase_d == PH_EXTRA) begin
        code = ST_TRUNC_EXTRA;
      end else if (phase_d == PH_FNAME) begin
        code = ST_TRUNC_NAME;
      end else if (phase_d == PH_FCOMMENT) begin
        code = ST_TRUNC_CMNT;
      end else if (phase_d == PH_HCRC) begin
        code = ST_TRUNC_HCRC;
      end else if (phase_d != PH_DATA) begin
        code = ST_SHORT;
      end else if (fill_d < tdepth) begin
        code = ST_TRUNC_DATA;
      end else begin
        code = ST_OK;
      end
      if (code == ST_OK) begin
        if (is_zlib) begin
          chk = {delay_d[0], delay_d[1], delay_d[2], delay_d[3]};
        end else begin
          chk = {delay_d[3], delay_d[2], delay_d[1], delay_d[0]};
          sz  = {delay_d[7], delay_d[6], delay_d[5], delay_d[4]};
        end
      end
    end

    pay_r.is_status      = 1'b0;
    pay_r.payload_byte   = emit_byte;
    pay_r.status_code    = ST_OK;
    pay_r.expected_check = 32'd0;
    pay_r.trailer_isize  = 32'd0;
    pay_r.last_of_run    = !in_last_i;

    st_r.is_status      = 1'b1;
    st_r.payload_byte   = 8'd0;
    st_r.status_code    = code;
    st_r.expected_check = chk;
    st_r.trailer_isize  = sz;
    st_r.last_of_run    = 1'b1;

    res_o.count  = 2'(emit) + 2'(in_last_i);
    res_o.first  = emit ? pay_r : st_r;
    res_o.second = st_r;

    if (in_last_i) begin
      phase_d = PH_FIXED;
      flags_d = 8'd0;
      first_d = 8'd0;
      skip_d  = 16'd0;
      bcnt_d  = 5'd0;
      fill_d  = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_RAW;
      phase_q <= PH_FIXED;
      flags_q <= 8'd0;
      first_q <= 8'd0;
      skip_q  <= 16'd0;
      bcnt_q  <= 5'd0;
      fill_q  <= '0;
      err_q   <= ST_OK;
    end else if (cfg_we_i) begin
      fmt_q   <= fmt_e'(cfg_fmt_i);
      phase_q <= PH_FIXED;
      flags_q <= 8'd0;
      first_q <= 8'd0;
      skip_q  <= 16'd0;
      bcnt_q  <= 5'd0;
      fill_q  <= '0;
      err_q   <= ST_OK;
    end else if (in_accept_i) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      first_q <= first_d;
      skip_q  <= skip_d;
      bcnt_q  <= bcnt_d;
      fill_q  <= fill_d;
      err_q   <= err_d;
    end
  end

  // trailer bytes are only read once the fill count says they were written
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      for (int i = 0; i < TrailerDepth; i++) begin
        delay_q[i] <= delay_d[i];
      end
    end
  end

endmodule
